FILE: rtl/gspc_pkg.sv
// shared types, constants and the exp2 root table for the gas sensor ppm converter
package gspc_pkg;

  // fixed-point setup
  localparam int ADC_FULL_SCALE = 4095;
  localparam int FRAC_BITS = 8;
  localparam int LOG2_10_Q16 = 217706;
  localparam int PPM_LIMIT = 100000;
  localparam int EXP_BIAS = 30 - FRAC_BITS;

  // widths
  localparam int RAW_W = 12;
  localparam int LOAD_W = 20;
  localparam int CNT_W = 12;
  localparam int COEF_W = 16;
  localparam int CLEAN_W = 17;
  localparam int SUM_W = 24;
  localparam int PPM_W = 25;
  localparam int VAL_W = 40;
  localparam int LOG_W = 24;
  localparam int DVS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [RAW_W-1:0] FS_RAW = RAW_W'(ADC_FULL_SCALE);
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [VAL_W-1:0] PPM_MAX = VAL_W'(PPM_LIMIT * (2 ** FRAC_BITS));

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD   = 3'd0,
    CFG_CALIB  = 3'd1,
    CFG_SLOPE  = 3'd2,
    CFG_ICEPT  = 3'd3,
    CFG_CLEAN  = 3'd4
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_MEAS_ERR   = 2'd1,
    ST_CAL_SAMPLE = 2'd2,
    ST_CAL_DONE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [LOAD_W-1:0]         load_resistance;
    logic [CNT_W-1:0]          calib_samples;
    logic signed [COEF_W-1:0]  curve_slope;
    logic signed [COEF_W-1:0]  curve_intercept;
    logic [CLEAN_W-1:0]        clean_air_ppm;
  } cfg_t;

  // datapath commands
  typedef enum logic [4:0] {
    DOP_NONE,
    DOP_ACCEPT,
    DOP_AVG_START,
    DOP_AVG_TAKE,
    DOP_RES_MUL,
    DOP_RES_DIV,
    DOP_RES_TAKE,
    DOP_LOG_R,
    DOP_LOG_R0,
    DOP_LOG_CLEAN,
    DOP_TAKE_L1,
    DOP_TAKE_L2,
    DOP_BL10_MUL,
    DOP_BL10_TAKE,
    DOP_SLOPE_MUL,
    DOP_T_MEAS,
    DOP_E_DIV,
    DOP_E_TAKE,
    DOP_T_CAL,
    DOP_EXP_START,
    DOP_R0_TAKE,
    DOP_R0_CLEAR,
    DOP_OUT_MEAS,
    DOP_OUT_ERR,
    DOP_OUT_SAMPLE,
    DOP_OUT_DONE
  } dp_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic cmd;
    logic calib_more;
    logic r_zero;
    logic r0_zero;
    logic cal_bad;
    logic div_done;
    logic log_done;
    logic exp_done;
  } dp_stat_t;

  typedef logic [15:0][30:0] root_tab_t;

  // q1.30 roots 2^(2^-(k+1)), each the integer square root of the previous one
  function automatic root_tab_t root_table();
    root_tab_t tab;
    logic [63:0] root;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    tab = '0;
    root = 64'd1 << 31;
    for (int k = 0; k < 16; k++) begin
      v = root << 30;
      res = '0;
      bt = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      root = res;
      tab[k] = res[30:0];
    end
    return tab;
  endfunction

endpackage

FILE: rtl/gspc_div.sv
// iterative restoring unsigned divider, one quotient bit per cycle
module gspc_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  logic               busy;
  logic [$clog2(DVD_W)-1:0] cnt;
  logic [DVS_W-1:0]   rem;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W:0]     acc;
  logic               fits;

  // trial subtract of the next partial remainder
  assign acc = {rem, quotient[DVD_W-1]};
  assign fits = acc >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= ($clog2(DVD_W))'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // payload: remainder and shifting quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= fits ? DVS_W'(acc - {1'b0, dvs}) : acc[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/gspc_dp.sv
// datapath: resistance, log2, exp2, calibration state and result register
module gspc_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  gspc_pkg::cfg_t          cfg,
  input  gspc_pkg::dp_op_t        op,
  input  logic                    cmd,
  input  logic [gspc_pkg::RAW_W-1:0] raw_sample,
  output gspc_pkg::dp_stat_t      stat,
  output logic [gspc_pkg::PPM_W-1:0] ppm_value,
  output logic [1:0]              status
);

  localparam int VW = gspc_pkg::VAL_W;
  localparam gspc_pkg::root_tab_t ROOTS = gspc_pkg::root_table();

  logic                          cmd_q;
  logic [gspc_pkg::RAW_W-1:0]    x_raw;
  logic [gspc_pkg::SUM_W-1:0]    calib_sum;
  logic [gspc_pkg::CNT_W-1:0]    calib_count;
  logic [gspc_pkg::CNT_W-1:0]    target;
  logic [VW-1:0]                 r_val;
  logic [VW-1:0]                 r0;
  logic signed [gspc_pkg::LOG_W-1:0] l1;
  logic signed [gspc_pkg::LOG_W-1:0] l2;
  logic signed [gspc_pkg::LOG_W-1:0] bl10;
  logic signed [VW-1:0]          e_val;
  logic signed [VW-1:0]          t_val;
  logic signed [63:0]            prod;
  logic signed [31:0]            mul_x;
  logic signed [31:0]            mul_y;
  logic signed [63:0]            mul_p;
  logic signed [24:0]            d_val;
  logic signed [24:0]            num_val;
  logic [24:0]                   num_mag;
  logic [gspc_pkg::DVS_W-1:0]    a_mag;
  logic                          e_neg;

  // divider hookup
  logic                          div_start;
  logic [VW-1:0]                 div_dvd;
  logic [gspc_pkg::DVS_W-1:0]    div_dvs;
  logic [VW-1:0]                 div_q;
  logic                          div_done;

  // log2 unit
  logic                          lg_start;
  logic [VW-1:0]                 lg_x;
  logic                          lg_x_fb;
  logic                          lg_busy;
  logic                          lg_norm;
  logic                          lg_sub;
  logic                          lg_done;
  logic                          lg_fb;
  logic [VW-1:0]                 lg_m;
  logic [5:0]                    lg_p;
  logic [3:0]                    lg_i;
  logic [61:0]                   lg_sq;
  logic [61:0]                   lg_sqp;
  logic [31:0]                   lg_mm;
  logic [15:0]                   lg_frac;
  logic signed [7:0]             lg_int;
  logic signed [gspc_pkg::LOG_W-1:0] lg_res;

  // exp2 unit
  logic                          ex_busy;
  logic                          ex_sub;
  logic                          ex_fin;
  logic                          ex_done;
  logic [3:0]                    ex_k;
  logic [30:0]                   ex_r;
  logic [61:0]                   ex_pr;
  logic [15:0]                   ex_f;
  logic signed [23:0]            ex_n;
  logic signed [24:0]            ex_s;
  logic [24:0]                   ex_ns;
  logic [63:0]                   ex_wide;
  logic [VW-1:0]                 ex_val;
  logic [VW-1:0]                 exp_res;

  // status to controller
  assign target = (cfg.calib_samples == '0) ? gspc_pkg::CNT_W'(1) : cfg.calib_samples;
  assign stat.cmd = cmd_q;
  assign stat.calib_more = calib_count < target;
  assign stat.r_zero = r_val == '0;
  assign stat.r0_zero = r0 == '0;
  assign stat.cal_bad = (cfg.curve_slope == '0) || (cfg.clean_air_ppm == '0);
  assign stat.div_done = div_done;
  assign stat.log_done = lg_done;
  assign stat.exp_done = ex_done;

  // log difference and calibration numerator
  assign d_val = 25'(l1) - 25'(l2);
  assign num_val = 25'(l2) - 25'(bl10);
  assign num_mag = num_val[24] ? 25'(-num_val) : 25'(num_val);
  assign a_mag = cfg.curve_slope[15] ? 16'(-cfg.curve_slope) : 16'(cfg.curve_slope);
  assign e_neg = num_val[24] ^ cfg.curve_slope[15];

  // shared multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (op)
      gspc_pkg::DOP_RES_MUL: begin
        mul_x = signed'({20'd0, gspc_pkg::FS_RAW - x_raw});
        mul_y = signed'({12'd0, cfg.load_resistance});
      end
      gspc_pkg::DOP_SLOPE_MUL: begin
        mul_x = 32'($signed(cfg.curve_slope));
        mul_y = 32'(d_val);
      end
      gspc_pkg::DOP_BL10_MUL: begin
        mul_x = 32'($signed(cfg.curve_intercept));
        mul_y = 32'(gspc_pkg::LOG2_10_Q16);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    case (op)
      gspc_pkg::DOP_AVG_START: begin
        div_start = 1'b1;
        div_dvd = VW'(calib_sum);
        div_dvs = gspc_pkg::DVS_W'(calib_count);
      end
      gspc_pkg::DOP_RES_DIV: begin
        div_start = 1'b1;
        div_dvd = VW'(prod[31:0]) << gspc_pkg::FRAC_BITS;
        div_dvs = gspc_pkg::DVS_W'(x_raw);
      end
      gspc_pkg::DOP_E_DIV: begin
        div_start = 1'b1;
        div_dvd = VW'(num_mag) << 12;
        div_dvs = a_mag;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  gspc_div #(
    .DVD_W(VW),
    .DVS_W(gspc_pkg::DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_sum <= '0;
      calib_count <= '0;
      r0 <= '0;
    end else begin
      case (op)
        gspc_pkg::DOP_ACCEPT: begin
          if (cmd) begin
            calib_sum <= calib_sum + gspc_pkg::SUM_W'(raw_sample);
            calib_count <= calib_count + 1'b1;
          end
        end
        gspc_pkg::DOP_AVG_TAKE: begin
          calib_sum <= '0;
          calib_count <= '0;
        end
        gspc_pkg::DOP_R0_TAKE: r0 <= exp_res;
        gspc_pkg::DOP_R0_CLEAR: r0 <= '0;
        default: begin
        end
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (op)
      gspc_pkg::DOP_ACCEPT: begin
        cmd_q <= cmd;
        x_raw <= raw_sample;
      end
      gspc_pkg::DOP_AVG_TAKE: x_raw <= div_q[gspc_pkg::RAW_W-1:0];
      gspc_pkg::DOP_RES_MUL, gspc_pkg::DOP_SLOPE_MUL, gspc_pkg::DOP_BL10_MUL: prod <= mul_p;
      gspc_pkg::DOP_RES_TAKE: begin
        if (x_raw == '0) begin
          r_val <= VW'(1) << gspc_pkg::FRAC_BITS;
        end else if (x_raw >= gspc_pkg::FS_RAW) begin
          r_val <= '0;
        end else begin
          r_val <= div_q;
        end
      end
      gspc_pkg::DOP_TAKE_L1: l1 <= lg_res;
      gspc_pkg::DOP_TAKE_L2: l2 <= lg_res;
      gspc_pkg::DOP_BL10_TAKE: bl10 <= gspc_pkg::LOG_W'(prod >>> 12);
      gspc_pkg::DOP_T_MEAS: t_val <= VW'(prod >>> 12) + VW'(bl10);
      gspc_pkg::DOP_E_TAKE: e_val <= e_neg ? -signed'(div_q) : signed'(div_q);
      gspc_pkg::DOP_T_CAL: t_val <= VW'(l1) - e_val;
      gspc_pkg::DOP_OUT_MEAS: begin
        if (exp_res == '0 || exp_res > gspc_pkg::PPM_MAX) begin
          ppm_value <= '0;
          status <= gspc_pkg::ST_MEAS_ERR;
        end else begin
          ppm_value <= exp_res[gspc_pkg::PPM_W-1:0];
          status <= gspc_pkg::ST_VALID;
        end
      end
      gspc_pkg::DOP_OUT_ERR: begin
        ppm_value <= '0;
        status <= gspc_pkg::ST_MEAS_ERR;
      end
      gspc_pkg::DOP_OUT_SAMPLE: begin
        ppm_value <= '0;
        status <= gspc_pkg::ST_CAL_SAMPLE;
      end
      gspc_pkg::DOP_OUT_DONE: begin
        ppm_value <= '0;
        status <= gspc_pkg::ST_CAL_DONE;
      end
      default: begin
      end
    endcase
  end

  // log2 source select
  always_comb begin
    lg_start = 1'b1;
    lg_x = r_val;
    lg_x_fb = 1'b1;
    case (op)
      gspc_pkg::DOP_LOG_R: lg_x = r_val;
      gspc_pkg::DOP_LOG_R0: lg_x = r0;
      gspc_pkg::DOP_LOG_CLEAN: begin
        lg_x = VW'(cfg.clean_air_ppm);
        lg_x_fb = 1'b0;
      end
      default: lg_start = 1'b0;
    endcase
  end

  // log2: normalize one bit a cycle, then square-and-compare per fraction bit
  assign lg_sqp = lg_m[VW-1:VW-31] * lg_m[VW-1:VW-31];
  assign lg_mm = lg_sq[61:30];
  assign lg_int = signed'({2'b00, lg_p}) - (lg_fb ? 8'(gspc_pkg::FRAC_BITS) : 8'd0);
  assign lg_res = {lg_int, lg_frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_busy <= 1'b0;
      lg_done <= 1'b0;
      lg_norm <= 1'b0;
      lg_sub <= 1'b0;
      lg_i <= '0;
    end else begin
      lg_done <= 1'b0;
      if (lg_start) begin
        lg_busy <= 1'b1;
        lg_norm <= 1'b1;
        lg_sub <= 1'b0;
        lg_i <= 4'd15;
      end else if (lg_busy) begin
        if (lg_norm) begin
          lg_norm <= ~lg_m[VW-1];
        end else begin
          lg_sub <= ~lg_sub;
          if (lg_sub) begin
            if (lg_i == '0) begin
              lg_busy <= 1'b0;
              lg_done <= 1'b1;
            end else begin
              lg_i <= lg_i - 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lg_start) begin
      lg_m <= lg_x;
      lg_p <= 6'(VW - 1);
      lg_fb <= lg_x_fb;
      lg_frac <= '0;
    end else if (lg_busy) begin
      if (lg_norm) begin
        if (!lg_m[VW-1]) begin
          lg_m <= lg_m << 1;
          lg_p <= lg_p - 1'b1;
        end
      end else if (!lg_sub) begin
        lg_sq <= lg_sqp;
      end else if (lg_mm[31]) begin
        lg_m[VW-1:VW-31] <= lg_mm[31:1];
        lg_frac[lg_i] <= 1'b1;
      end else begin
        lg_m[VW-1:VW-31] <= lg_mm[30:0];
      end
    end
  end

  // exp2 final scaling to q.frac_bits with saturation
  always_comb begin
    ex_s = 25'(ex_n) - 25'(gspc_pkg::EXP_BIAS);
    ex_ns = 25'(-ex_s);
    ex_wide = 64'(ex_r) << ex_s[5:0];
    if (!ex_s[24]) begin
      if (ex_s >= 25'sd33 || ex_wide > 64'(gspc_pkg::VAL_MAX)) begin
        ex_val = gspc_pkg::VAL_MAX;
      end else begin
        ex_val = ex_wide[VW-1:0];
      end
    end else if (ex_ns >= 25'd31) begin
      ex_val = '0;
    end else begin
      ex_val = VW'(ex_r >> ex_ns[4:0]);
    end
  end

  // exp2: one root product per fraction bit, a multiply step and then a take step
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_busy <= 1'b0;
      ex_sub <= 1'b0;
      ex_fin <= 1'b0;
      ex_done <= 1'b0;
      ex_k <= '0;
    end else begin
      ex_done <= 1'b0;
      if (op == gspc_pkg::DOP_EXP_START) begin
        ex_busy <= 1'b1;
        ex_sub <= 1'b0;
        ex_k <= '0;
      end else if (ex_busy) begin
        ex_sub <= ~ex_sub;
        if (ex_sub) begin
          if (ex_k == 4'd15) begin
            ex_busy <= 1'b0;
            ex_fin <= 1'b1;
          end else begin
            ex_k <= ex_k + 1'b1;
          end
        end
      end else if (ex_fin) begin
        ex_fin <= 1'b0;
        ex_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == gspc_pkg::DOP_EXP_START) begin
      ex_f <= t_val[15:0];
      ex_n <= t_val[VW-1:16];
      ex_r <= 31'd1 << 30;
    end else if (ex_busy) begin
      if (!ex_sub) begin
        ex_pr <= ex_r * ROOTS[ex_k];
      end else if (ex_f[4'd15 - ex_k]) begin
        ex_r <= ex_pr[60:30];
      end
    end else if (ex_fin) begin
      exp_res <= ex_val;
    end
  end

endmodule

FILE: rtl/gspc_ctrl.sv
// controller: sequences the datapath for measurement and calibration requests
module gspc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gspc_pkg::dp_stat_t  stat,
  output gspc_pkg::dp_op_t    op
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_AVG_WAIT,
    S_RES_MUL,
    S_RES_DIV,
    S_RES_WAIT,
    S_BRANCH,
    S_LOG1_WAIT,
    S_LOG_R0,
    S_LOG2_WAIT,
    S_BL10_MUL,
    S_BL10_TAKE,
    S_SLOPE,
    S_T_MEAS,
    S_E_DIV,
    S_E_WAIT,
    S_LOG_R,
    S_T_CAL,
    S_EXP,
    S_EXP_WAIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  gspc_pkg::dp_op_t out_kind;
  gspc_pkg::dp_op_t out_kind_next;

  assign in_ready = state == S_IDLE;

  // next state and datapath command
  always_comb begin
    state_next = state;
    out_kind_next = out_kind;
    op = gspc_pkg::DOP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = gspc_pkg::DOP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.cmd) begin
          state_next = S_RES_MUL;
        end else if (stat.calib_more) begin
          out_kind_next = gspc_pkg::DOP_OUT_SAMPLE;
          state_next = S_OUT;
        end else begin
          op = gspc_pkg::DOP_AVG_START;
          state_next = S_AVG_WAIT;
        end
      end
      S_AVG_WAIT: begin
        if (stat.div_done) begin
          op = gspc_pkg::DOP_AVG_TAKE;
          state_next = S_RES_MUL;
        end
      end
      S_RES_MUL: begin
        op = gspc_pkg::DOP_RES_MUL;
        state_next = S_RES_DIV;
      end
      S_RES_DIV: begin
        op = gspc_pkg::DOP_RES_DIV;
        state_next = S_RES_WAIT;
      end
      S_RES_WAIT: begin
        if (stat.div_done) begin
          op = gspc_pkg::DOP_RES_TAKE;
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (!stat.cmd) begin
          if (stat.r_zero || stat.r0_zero) begin
            out_kind_next = gspc_pkg::DOP_OUT_ERR;
            state_next = S_OUT;
          end else begin
            op = gspc_pkg::DOP_LOG_R;
            state_next = S_LOG1_WAIT;
          end
        end else if (stat.r_zero || stat.cal_bad) begin
          op = gspc_pkg::DOP_R0_CLEAR;
          out_kind_next = gspc_pkg::DOP_OUT_DONE;
          state_next = S_OUT;
        end else begin
          op = gspc_pkg::DOP_LOG_CLEAN;
          state_next = S_LOG2_WAIT;
        end
      end
      S_LOG1_WAIT: begin
        if (stat.log_done) begin
          op = gspc_pkg::DOP_TAKE_L1;
          state_next = stat.cmd ? S_T_CAL : S_LOG_R0;
        end
      end
      S_LOG_R0: begin
        op = gspc_pkg::DOP_LOG_R0;
        state_next = S_LOG2_WAIT;
      end
      S_LOG2_WAIT: begin
        if (stat.log_done) begin
          op = gspc_pkg::DOP_TAKE_L2;
          state_next = S_BL10_MUL;
        end
      end
      S_BL10_MUL: begin
        op = gspc_pkg::DOP_BL10_MUL;
        state_next = S_BL10_TAKE;
      end
      S_BL10_TAKE: begin
        op = gspc_pkg::DOP_BL10_TAKE;
        state_next = stat.cmd ? S_E_DIV : S_SLOPE;
      end
      S_SLOPE: begin
        op = gspc_pkg::DOP_SLOPE_MUL;
        state_next = S_T_MEAS;
      end
      S_T_MEAS: begin
        op = gspc_pkg::DOP_T_MEAS;
        state_next = S_EXP;
      end
      S_E_DIV: begin
        op = gspc_pkg::DOP_E_DIV;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (stat.div_done) begin
          op = gspc_pkg::DOP_E_TAKE;
          state_next = S_LOG_R;
        end
      end
      S_LOG_R: begin
        op = gspc_pkg::DOP_LOG_R;
        state_next = S_LOG1_WAIT;
      end
      S_T_CAL: begin
        op = gspc_pkg::DOP_T_CAL;
        state_next = S_EXP;
      end
      S_EXP: begin
        op = gspc_pkg::DOP_EXP_START;
        state_next = S_EXP_WAIT;
      end
      S_EXP_WAIT: begin
        if (stat.exp_done) begin
          if (stat.cmd) begin
            op = gspc_pkg::DOP_R0_TAKE;
            out_kind_next = gspc_pkg::DOP_OUT_DONE;
          end else begin
            out_kind_next = gspc_pkg::DOP_OUT_MEAS;
          end
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          op = out_kind;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_kind <= gspc_pkg::DOP_OUT_ERR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_kind <= out_kind_next;
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/gas_sensor_ppm_converter_core.sv
// top level of the gas sensor ppm converter: config registers, controller, datapath
//
// Input requests (cmd, raw_sample) arrive on a valid/ready channel; cmd 1 is a
// calibration sample, cmd 0 a measurement. Every request gives exactly one
// result (ppm_value in unsigned Q17.8, status) on a valid/ready output channel.
// One request is worked on at a time: in_ready is high only while idle.
// A calibration sample that does not finish a run goes from decode to its result.
// A measurement runs the iterative divider for the resistance, two log2 passes
// (normalize, then one squaring step per fraction bit each) and one exp2 pass;
// a finishing calibration sample also runs the divider for the average and for
// the division by the slope, and the log2/exp2 units work one bit per step.
// The result waits in an output register; the next request is taken while it
// waits, and its result is held back until the receiver takes the first one.
// Reset returns the registers to their defaults, clears the calibration sum and
// count, and leaves the block uncalibrated (measurements report an error).
// Configuration writes are taken at any edge with cfg_we high and rst low.
module gas_sensor_ppm_converter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [gspc_pkg::RAW_W-1:0]          raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gspc_pkg::PPM_W-1:0]          ppm_value,
  output logic [1:0]                          status,
  input  logic                                cfg_we,
  input  logic [gspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gspc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  gspc_pkg::cfg_t      cfg;
  gspc_pkg::dp_op_t    op;
  gspc_pkg::dp_stat_t  stat;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.load_resistance <= 20'd10000;
      cfg.calib_samples <= 12'd100;
      cfg.curve_slope <= -16'sd1720;
      cfg.curve_intercept <= 16'sd7864;
      cfg.clean_air_ppm <= 17'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        gspc_pkg::CFG_LOAD:  cfg.load_resistance <= cfg_data;
        gspc_pkg::CFG_CALIB: cfg.calib_samples <= cfg_data[gspc_pkg::CNT_W-1:0];
        gspc_pkg::CFG_SLOPE: cfg.curve_slope <= signed'(cfg_data[gspc_pkg::COEF_W-1:0]);
        gspc_pkg::CFG_ICEPT: cfg.curve_intercept <= signed'(cfg_data[gspc_pkg::COEF_W-1:0]);
        gspc_pkg::CFG_CLEAN: cfg.clean_air_ppm <= cfg_data[gspc_pkg::CLEAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gspc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  gspc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .op         (op),
    .cmd        (cmd),
    .raw_sample (raw_sample),
    .stat       (stat),
    .ppm_value  (ppm_value),
    .status     (status)
  );

  // one request at a time: ready drops right after an accept
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // non-valid results carry a zero ppm value
  a_zero_on_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != gspc_pkg::ST_VALID) |-> ppm_value == '0)
    else $error("ppm value nonzero on a non-valid status");

  // valid ppm results are nonzero and within the limit
  a_ppm_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == gspc_pkg::ST_VALID) |->
      (ppm_value != '0 && ppm_value <= gspc_pkg::PPM_MAX[gspc_pkg::PPM_W-1:0]))
    else $error("valid ppm result out of range");

endmodule
